// ===== rtl/core/emc_pkg.sv =====
// ----------------------------------------------------------------------------
// emc_pkg
// Shared types, constants and saturating Q8.24 arithmetic for the
// excitable-medium cell update.
// ----------------------------------------------------------------------------
package emc_pkg;

  localparam int ValW     = 32;
  localparam int FracBits = 24;
  localparam int CfgIdxW  = 3;

  typedef logic signed [ValW-1:0] val_t;

  localparam val_t VMAX = 32'sh7fff_ffff;
  localparam val_t VMIN = 32'sh8000_0000;
  localparam val_t ONE  = 32'sh0100_0000;
  localparam val_t SIX  = 32'sh0600_0000;

  localparam logic [CfgIdxW-1:0] REG_DIFFUSION_WEIGHT      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TIME_STEP             = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_REACTION_GAIN         = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_EXCITATION_THRESHOLD  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RECOVERY_OFFSET       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RECOVERY_BASE_RATE    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_RECOVERY_NUMER_GAIN   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_RECOVERY_DENOM_OFFSET = 3'd7;

  typedef struct packed {
    val_t potential_center;
    val_t potential_x_plus;
    val_t potential_x_minus;
    val_t potential_y_plus;
    val_t potential_y_minus;
    val_t potential_z_plus;
    val_t potential_z_minus;
    val_t recovery_now;
  } cell_t;

  typedef struct packed {
    val_t potential_next;
    val_t recovery_next;
  } res_t;

  typedef struct packed {
    val_t lam;
    val_t dt;
    val_t k;
    val_t a;
    val_t bp1;
    val_t eps;
    val_t mu1;
    val_t mu2;
    val_t gam;
    val_t dtk;
  } cfg_t;

  // values that ride alongside the division
  typedef struct packed {
    val_t en;
    val_t r;
    val_t drive;
  } side_t;

  function automatic val_t sadd(val_t a, val_t b);
    logic signed [ValW:0] s;
    s = (ValW+1)'(a) + (ValW+1)'(b);
    if (s[ValW] != s[ValW-1]) return s[ValW] ? VMIN : VMAX;
    return val_t'(s[ValW-1:0]);
  endfunction

  function automatic val_t ssub(val_t a, val_t b);
    logic signed [ValW:0] s;
    s = (ValW+1)'(a) - (ValW+1)'(b);
    if (s[ValW] != s[ValW-1]) return s[ValW] ? VMIN : VMAX;
    return val_t'(s[ValW-1:0]);
  endfunction

  // product floored by the fraction bits, then saturated
  function automatic val_t smul(val_t a, val_t b);
    logic signed [2*ValW-1:0] p;
    p = (2*ValW)'(a) * (2*ValW)'(b);
    if (p[2*ValW-1:ValW+FracBits-1] != {(ValW-FracBits+1){p[ValW+FracBits-1]}})
      return p[2*ValW-1] ? VMIN : VMAX;
    return val_t'(p[ValW+FracBits-1:FracBits]);
  endfunction

endpackage

// ===== rtl/core/emc_if.sv =====
// ----------------------------------------------------------------------------
// emc_cell_if / emc_result_if
// Valid/ready channels for cell items and result items.
// ----------------------------------------------------------------------------
interface emc_cell_if import emc_pkg::*;;
  logic  valid;
  logic  ready;
  cell_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface emc_result_if import emc_pkg::*;;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/emc_cfg.sv =====
// ----------------------------------------------------------------------------
// emc_cfg
// Configuration registers plus the derived centre weight and dt*k.
// ----------------------------------------------------------------------------
module emc_cfg import emc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  val_t               cfg_data,
  output cfg_t               cfg
);

  val_t lam, dt, k, a, bp1, eps, mu1, mu2;
  val_t lam6, gam, dtk;

  always_ff @(posedge clk) begin
    if (rst) begin
      lam  <= '0;
      dt   <= '0;
      k    <= '0;
      a    <= '0;
      bp1  <= '0;
      eps  <= '0;
      mu1  <= '0;
      mu2  <= '0;
      lam6 <= '0;
      gam  <= ONE;
      dtk  <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_DIFFUSION_WEIGHT:      lam <= cfg_data;
          REG_TIME_STEP:             dt  <= cfg_data;
          REG_REACTION_GAIN:         k   <= cfg_data;
          REG_EXCITATION_THRESHOLD:  a   <= cfg_data;
          REG_RECOVERY_OFFSET:       bp1 <= cfg_data;
          REG_RECOVERY_BASE_RATE:    eps <= cfg_data;
          REG_RECOVERY_NUMER_GAIN:   mu1 <= cfg_data;
          REG_RECOVERY_DENOM_OFFSET: mu2 <= cfg_data;
        endcase
      end
      // derived terms are registered: lam6 and dtk from the parameter registers, gam from lam6
      lam6 <= smul(lam, SIX);
      gam  <= ssub(ONE, lam6);
      dtk  <= smul(dt, k);
    end
  end

  assign cfg = '{lam: lam, dt: dt, k: k, a: a, bp1: bp1, eps: eps, mu1: mu1,
                 mu2: mu2, gam: gam, dtk: dtk};

endmodule

// ===== rtl/core/emc_front.sv =====
// ----------------------------------------------------------------------------
// emc_front
// Stencil sum, reaction and coupling terms of the new potential, plus the
// recovery drive and the division operands.
// ----------------------------------------------------------------------------
module emc_front import emc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  cell_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output val_t  out_num,
  output val_t  out_den,
  output side_t out_side
);

  localparam int NS = 9;

  typedef struct packed {
    val_t       e;
    val_t       r;
    val_t [5:0] nb;
    val_t       acc;
    val_t       mr;
    val_t       den;
    val_t       ke;
    val_t       ebp;
    val_t       dte;
    val_t       dtke;
    val_t       ea;
    val_t       drive;
    val_t       en;
  } fr_t;

  function automatic fr_t step(int unsigned i, fr_t s, cfg_t c);
    fr_t o;
    o = s;
    case (i)
      0: begin
        o.acc  = sadd(s.nb[0], s.nb[1]);
        o.mr   = smul(c.mu1, s.r);
        o.den  = sadd(c.mu2, s.e);
        o.ke   = smul(c.k, s.e);
        o.ebp  = ssub(s.e, c.bp1);
        o.dte  = smul(c.dt, s.e);
        o.dtke = smul(c.dtk, s.e);
        o.ea   = ssub(s.e, c.a);
      end
      1: begin
        o.acc   = sadd(s.acc, s.nb[2]);
        o.drive = smul(s.ke, s.ebp);
        o.dte   = smul(s.dte, s.r);
        o.dtke  = smul(s.dtke, s.ea);
        o.ea    = ssub(s.e, ONE);
      end
      2: begin
        o.acc   = sadd(s.acc, s.nb[3]);
        o.drive = sadd(s.r, s.drive);
        o.dtke  = smul(s.dtke, s.ea);
      end
      3: o.acc = sadd(s.acc, s.nb[4]);
      4: o.acc = sadd(s.acc, s.nb[5]);
      5: begin
        o.ke  = smul(c.lam, s.acc);
        o.ebp = smul(c.gam, s.e);
      end
      6: o.en = sadd(s.ke, s.ebp);
      7: o.en = ssub(s.en, s.dtke);
      8: o.en = ssub(s.en, s.dte);
      default: o = s;
    endcase
    return o;
  endfunction

  logic [NS:0]   v;
  logic [NS+1:0] take;
  fr_t           s [NS+1];
  fr_t           ld;

  always_comb begin
    take[NS+1] = out_ready;
    for (int i = NS; i >= 0; i--) take[i] = !v[i] || take[i+1];
  end

  always_comb begin
    ld       = '0;
    ld.e     = in_data.potential_center;
    ld.r     = in_data.recovery_now;
    ld.nb[0] = in_data.potential_x_plus;
    ld.nb[1] = in_data.potential_x_minus;
    ld.nb[2] = in_data.potential_y_plus;
    ld.nb[3] = in_data.potential_y_minus;
    ld.nb[4] = in_data.potential_z_plus;
    ld.nb[5] = in_data.potential_z_minus;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (take[0]) v[0] <= in_valid;
      for (int i = 1; i <= NS; i++) begin
        if (take[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take[0]) s[0] <= ld;
    for (int i = 1; i <= NS; i++) begin
      if (take[i]) s[i] <= step(i - 1, s[i-1], cfg);
    end
  end

  assign in_ready  = take[0];
  assign out_valid = v[NS];
  assign out_num   = s[NS].mr;
  assign out_den   = s[NS].den;
  assign out_side  = '{en: s[NS].en, r: s[NS].r, drive: s[NS].drive};

endmodule

// ===== rtl/core/emc_div.sv =====
// ----------------------------------------------------------------------------
// emc_div
// Pipelined restoring divider, one quotient bit per stage, giving the
// saturated Q8.24 quotient num / den.
// ----------------------------------------------------------------------------
module emc_div import emc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  val_t  in_num,
  input  val_t  in_den,
  input  side_t in_side,
  output logic  out_valid,
  input  logic  out_ready,
  output val_t  out_quot,
  output side_t out_side
);

  localparam int NS = ValW + 2;

  typedef struct packed {
    val_t            n;
    val_t            d;
    logic [ValW-1:0] rem;
    logic [ValW-1:0] low;
    logic [ValW-1:0] q;
    logic [ValW-1:0] ud;
    logic            neg;
    logic            sat;
    val_t            satv;
    side_t           side;
  } dv_t;

  function automatic dv_t step(int unsigned i, dv_t s);
    dv_t             o;
    logic [ValW-1:0] un;
    logic [ValW:0]   t;
    logic            qb;
    o  = s;
    un = '0;
    t  = '0;
    qb = 1'b0;
    if (i == 0) begin
      un    = s.n[ValW-1] ? (~s.n + 1'b1) : s.n;
      o.ud  = s.d[ValW-1] ? (~s.d + 1'b1) : s.d;
      o.neg = s.n[ValW-1] ^ s.d[ValW-1];
      o.rem = ValW'(un >> (ValW - FracBits));
      o.low = {un[ValW-FracBits-1:0], {FracBits{1'b0}}};
      o.q   = '0;
      o.sat = 1'b0;
      o.satv = VMAX;
      if (s.d == '0) begin
        o.sat  = 1'b1;
        o.satv = s.n[ValW-1] ? VMIN : VMAX;
      end else if (ValW'(un >> (ValW - FracBits)) >= o.ud) begin
        // quotient needs more than the word: saturate
        o.sat  = 1'b1;
        o.satv = o.neg ? VMIN : VMAX;
      end
    end else if (i <= ValW) begin
      t = {s.rem, s.low[ValW-1]};
      if (t >= {1'b0, s.ud}) begin
        t  = t - {1'b0, s.ud};
        qb = 1'b1;
      end
      o.rem = t[ValW-1:0];
      o.low = {s.low[ValW-2:0], 1'b0};
      o.q   = {s.q[ValW-2:0], qb};
    end else begin
      if (s.sat) o.n = s.satv;
      else if (s.neg) o.n = (s.q > {1'b1, {(ValW-1){1'b0}}}) ? VMIN : val_t'(~s.q + 1'b1);
      else o.n = s.q[ValW-1] ? VMAX : val_t'(s.q);
    end
    return o;
  endfunction

  logic [NS:0]   v;
  logic [NS+1:0] take;
  dv_t           s [NS+1];
  dv_t           ld;

  always_comb begin
    take[NS+1] = out_ready;
    for (int i = NS; i >= 0; i--) take[i] = !v[i] || take[i+1];
  end

  always_comb begin
    ld      = '0;
    ld.n    = in_num;
    ld.d    = in_den;
    ld.side = in_side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (take[0]) v[0] <= in_valid;
      for (int i = 1; i <= NS; i++) begin
        if (take[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take[0]) s[0] <= ld;
    for (int i = 1; i <= NS; i++) begin
      if (take[i]) s[i] <= step(i - 1, s[i-1]);
    end
  end

  assign in_ready  = take[0];
  assign out_valid = v[NS];
  assign out_quot  = s[NS].n;
  assign out_side  = s[NS].side;

endmodule

// ===== rtl/core/emc_back.sv =====
// ----------------------------------------------------------------------------
// emc_back
// Recovery update from the rate quotient, and the result register.
// ----------------------------------------------------------------------------
module emc_back import emc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  val_t  in_quot,
  input  side_t in_side,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_data
);

  localparam int NS = 4;

  typedef struct packed {
    val_t  q;
    val_t  t;
    side_t side;
  } bk_t;

  function automatic bk_t step(int unsigned i, bk_t s, cfg_t c);
    bk_t o;
    o = s;
    case (i)
      0: o.t = sadd(c.eps, s.q);
      1: o.t = smul(s.t, s.side.drive);
      2: o.t = smul(c.dt, s.t);
      3: o.t = ssub(s.side.r, s.t);
      default: o = s;
    endcase
    return o;
  endfunction

  logic [NS:0]   v;
  logic [NS+1:0] take;
  bk_t           s [NS+1];

  always_comb begin
    take[NS+1] = out_ready;
    for (int i = NS; i >= 0; i--) take[i] = !v[i] || take[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (take[0]) v[0] <= in_valid;
      for (int i = 1; i <= NS; i++) begin
        if (take[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take[0]) s[0] <= '{q: in_quot, t: '0, side: in_side};
    for (int i = 1; i <= NS; i++) begin
      if (take[i]) s[i] <= step(i - 1, s[i-1], cfg);
    end
  end

  assign in_ready  = take[0];
  assign out_valid = v[NS];
  assign out_data  = '{potential_next: s[NS].side.en, recovery_next: s[NS].t};

endmodule

// ===== rtl/core/excitable_medium_cell_update.sv =====
// ----------------------------------------------------------------------------
// excitable_medium_cell_update
// One explicit Euler step of an excitable-medium cell on a 7-point stencil.
// ----------------------------------------------------------------------------
// cell_in carries a cell's potential, its six face neighbours and its
// recovery value; cell_out returns the new potential and recovery value,
// one result per cell, in arrival order. A transaction completes on a clock
// edge with valid and ready both high.
// The eight parameter registers are written through cfg_write/cfg_index/
// cfg_data, by the user only while no cell is in flight; the block itself
// does not enforce this. The input transaction is captured into the first
// of 50 register stages, 10 of stencil and product terms, 35 of the
// divider (one quotient bit per stage) and 5 of the recovery update and
// output register.
// Throughput is one cell per cycle while cell_out is not stalled.
// When cell_out stalls, results hold in their stages and empty stages still
// take new cells, so ready drops only once the whole pipeline is full.
// Synchronous reset empties the pipeline and clears all parameter registers.
// ----------------------------------------------------------------------------
module excitable_medium_cell_update import emc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  val_t               cfg_data,
  emc_cell_if.sink           cell_in,
  emc_result_if.source       cell_out
);

  cfg_t  cfg;
  logic  fr_valid, fr_ready;
  val_t  fr_num, fr_den;
  side_t fr_side;
  logic  dv_valid, dv_ready;
  val_t  dv_quot;
  side_t dv_side;

  emc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  emc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (cell_in.valid),
    .in_ready  (cell_in.ready),
    .in_data   (cell_in.data),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_num   (fr_num),
    .out_den   (fr_den),
    .out_side  (fr_side)
  );

  emc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_num    (fr_num),
    .in_den    (fr_den),
    .in_side   (fr_side),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  emc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_quot   (dv_quot),
    .in_side   (dv_side),
    .out_valid (cell_out.valid),
    .out_ready (cell_out.ready),
    .out_data  (cell_out.data)
  );

endmodule

// ===== tb/excitable_medium_cell_check.sv =====
// ----------------------------------------------------------------------------
// excitable_medium_cell_check
// Watches the config port and both channels. It keeps its own copy of the
// parameter registers, predicts each cell update in saturating Q8.24, and
// compares every result transaction in order.
// ----------------------------------------------------------------------------
module excitable_medium_cell_check import emc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  val_t               cfg_data,
  emc_cell_if                cell_ch,
  emc_result_if              res_ch,
  output int                 outstanding,
  output int                 fails,
  output int                 results_seen
);

  val_t params [8];
  res_t updates_due [$];

  function automatic val_t clip(longint x);
    if (x > longint'(VMAX)) return VMAX;
    if (x < longint'(VMIN)) return VMIN;
    return val_t'(x);
  endfunction

  function automatic val_t q_add(val_t a, val_t b);
    return clip(longint'(a) + longint'(b));
  endfunction

  function automatic val_t q_sub(val_t a, val_t b);
    return clip(longint'(a) - longint'(b));
  endfunction

  // floor of the product by the fraction bits
  function automatic val_t q_mul(val_t a, val_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip(p >>> FracBits);
  endfunction

  function automatic val_t q_div(val_t n, val_t d);
    longint q;
    if (d == 0) return (n >= 0) ? VMAX : VMIN;
    q = (longint'(n) <<< FracBits) / longint'(d);
    return clip(q);
  endfunction

  function automatic res_t euler_update(cell_t c);
    val_t lam, dt, k, a, bp1, eps, mu1, mu2;
    val_t e, r, nsum, gam, dtk, en, rate, drive;
    res_t o;
    lam = params[REG_DIFFUSION_WEIGHT];
    dt  = params[REG_TIME_STEP];
    k   = params[REG_REACTION_GAIN];
    a   = params[REG_EXCITATION_THRESHOLD];
    bp1 = params[REG_RECOVERY_OFFSET];
    eps = params[REG_RECOVERY_BASE_RATE];
    mu1 = params[REG_RECOVERY_NUMER_GAIN];
    mu2 = params[REG_RECOVERY_DENOM_OFFSET];
    e = c.potential_center;
    r = c.recovery_now;
    nsum = q_add(c.potential_x_plus, c.potential_x_minus);
    nsum = q_add(nsum, c.potential_y_plus);
    nsum = q_add(nsum, c.potential_y_minus);
    nsum = q_add(nsum, c.potential_z_plus);
    nsum = q_add(nsum, c.potential_z_minus);
    gam = q_sub(ONE, q_mul(lam, SIX));
    dtk = q_mul(dt, k);
    en = q_add(q_mul(lam, nsum), q_mul(gam, e));
    en = q_sub(en, q_mul(q_mul(q_mul(dtk, e), q_sub(e, a)), q_sub(e, ONE)));
    en = q_sub(en, q_mul(q_mul(dt, e), r));
    rate  = q_add(eps, q_div(q_mul(mu1, r), q_add(mu2, e)));
    drive = q_add(r, q_mul(q_mul(k, e), q_sub(e, bp1)));
    o.potential_next = en;
    o.recovery_next  = q_sub(r, q_mul(dt, q_mul(rate, drive)));
    return o;
  endfunction

  assign outstanding = updates_due.size();

  always @(posedge clk) begin
    res_t want;
    int   bad;
    bad = 0;
    if (rst) begin
      foreach (params[i]) params[i] <= '0;
      updates_due.delete();
      fails <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_write) params[cfg_index] <= cfg_data;
      if (cell_ch.valid && cell_ch.ready) updates_due.push_back(euler_update(cell_ch.data));
      if (res_ch.valid && res_ch.ready) begin
        results_seen <= results_seen + 1;
        if (updates_due.size() == 0) begin
          $error("result transaction with no cell pending");
          bad = bad + 1;
        end else begin
          want = updates_due.pop_front();
          if (res_ch.data.potential_next !== want.potential_next) begin
            $error("potential_next: expected %0d, actual %0d",
                   want.potential_next, res_ch.data.potential_next);
            bad = bad + 1;
          end
          if (res_ch.data.recovery_next !== want.recovery_next) begin
            $error("recovery_next: expected %0d, actual %0d",
                   want.recovery_next, res_ch.data.recovery_next);
            bad = bad + 1;
          end
        end
      end
      if (bad != 0) fails <= fails + bad;
    end
  end

endmodule

// ===== tb/excitable_medium_cell_update_test.sv =====
// ----------------------------------------------------------------------------
// excitable_medium_cell_update_test
// Drives cells through the update block under several parameter sets:
// directed extremes and zero-divisor cells, then random cells with random
// gaps on both channels, one long output stall and one gap-free stretch.
// ----------------------------------------------------------------------------
module excitable_medium_cell_update_test;
  import emc_pkg::*;

  localparam int ItemsPerSet = 170;
  localparam int IdleLimit   = 5000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  val_t               cfg_data = '0;
  int                 outstanding, fails, results_seen;
  int                 cells_sent = 0;
  int                 stall_cycles = 0;
  int                 idle_count = 0;
  bit                 no_gaps = 1'b0;
  val_t               cur_mu2 = '0;

  emc_cell_if   cell_ch ();
  emc_result_if res_ch ();

  initial begin
    cell_ch.valid = 1'b0;
    cell_ch.data  = '0;
    res_ch.ready  = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  excitable_medium_cell_update uut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cell_in(cell_ch.sink), .cell_out(res_ch.source)
  );

  excitable_medium_cell_check chk (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cell_ch(cell_ch), .res_ch(res_ch),
    .outstanding(outstanding), .fails(fails), .results_seen(results_seen)
  );

  // receiver: random back-pressure, plus one long hold-off
  always @(posedge clk) begin
    if (stall_cycles > 0) begin
      res_ch.ready <= 1'b0;
      stall_cycles <= stall_cycles - 1;
    end else begin
      res_ch.ready <= no_gaps || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    if (rst || (cell_ch.valid && cell_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= IdleLimit) begin
      $display("timeout after %0d quiet cycles", idle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_params(input val_t vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CfgIdxW'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    cur_mu2 = vals[REG_RECOVERY_DENOM_OFFSET];
    repeat (4) @(posedge clk);
  endtask

  task automatic send_cell(input cell_t c);
    while (!no_gaps && $urandom_range(99) < 26) begin
      cell_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cell_ch.valid <= 1'b1;
    cell_ch.data  <= c;
    @(posedge clk);
    while (!cell_ch.ready) @(posedge clk);
    cells_sent++;
  endtask

  task automatic drain;
    cell_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // magnitude range varies from full scale down to 2^-10 of full scale
  function automatic val_t rand_val();
    return val_t'($urandom) >>> $urandom_range(10);
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    c = {rand_val(), rand_val(), rand_val(), rand_val(),
         rand_val(), rand_val(), rand_val(), rand_val()};
    if ($urandom_range(99) < 40) begin
      // physiological range: potentials in [0,1], recovery in [0,2]
      c.potential_center  = val_t'($urandom_range(32'h0100_0000));
      c.potential_x_plus  = val_t'($urandom_range(32'h0100_0000));
      c.potential_x_minus = val_t'($urandom_range(32'h0100_0000));
      c.potential_y_plus  = val_t'($urandom_range(32'h0100_0000));
      c.potential_y_minus = val_t'($urandom_range(32'h0100_0000));
      c.potential_z_plus  = val_t'($urandom_range(32'h0100_0000));
      c.potential_z_minus = val_t'($urandom_range(32'h0100_0000));
      c.recovery_now      = val_t'($urandom_range(32'h0200_0000));
    end
    if ($urandom_range(99) < 8) c.potential_center = -cur_mu2;  // divisor hits zero
    return c;
  endfunction

  function automatic cell_t flat_cell(val_t v);
    return {v, v, v, v, v, v, v, v};
  endfunction

  initial begin
    val_t  set [8];
    cell_t c;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers still at reset: every parameter zero
    for (int i = 0; i < 10; i++) send_cell(rand_cell());
    drain();

    // typical parameters: lambda .1, dt .01, k 8, a .15, b+1 1.1,
    // eps .002, mu1 .2, mu2 .3
    set = '{32'sh0019_999a, 32'sh0002_8f5c, 32'sh0800_0000, 32'sh0026_6666,
            32'sh0119_999a, 32'sh0000_8312, 32'sh0033_3333, 32'sh004c_cccd};
    write_params(set);
    send_cell(flat_cell('0));
    send_cell(flat_cell(VMAX));
    send_cell(flat_cell(VMIN));
    send_cell(flat_cell(ONE));
    send_cell(flat_cell(32'sh5555_5555));
    send_cell(flat_cell(32'shaaaa_aaaa));
    send_cell({VMAX, VMIN, VMAX, VMIN, VMAX, VMIN, VMAX, VMIN});
    send_cell({VMIN, VMAX, VMIN, VMAX, VMIN, VMAX, VMIN, VMAX});
    c = flat_cell(ONE);
    c.potential_center = -cur_mu2;
    send_cell(c);                       // zero divisor, positive numerator
    c.recovery_now = -ONE;
    send_cell(c);                       // zero divisor, negative numerator
    c.recovery_now = '0;
    send_cell(c);                       // zero divisor, zero numerator
    c = flat_cell(32'sh0080_0000);
    c.potential_center = 32'sh0026_6666;
    send_cell(c);                       // at threshold
    c.potential_center = -32'sh0000_0001;
    send_cell(c);
    for (int i = 0; i < ItemsPerSet; i++) begin
      if (i == 60) stall_cycles = 300;  // output held off, pipeline fills
      send_cell(rand_cell());
    end
    drain();

    set = '{VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX};
    write_params(set);
    send_cell(flat_cell(VMAX));
    send_cell(flat_cell(VMIN));
    for (int i = 0; i < ItemsPerSet; i++) send_cell(rand_cell());
    drain();

    set = '{VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN};
    write_params(set);
    send_cell(flat_cell(VMAX));
    send_cell(flat_cell(VMIN));
    for (int i = 0; i < ItemsPerSet; i++) send_cell(rand_cell());
    drain();

    for (int p = 0; p < 2; p++) begin
      foreach (set[i]) set[i] = rand_val();
      write_params(set);
      for (int i = 0; i < ItemsPerSet; i++) begin
        no_gaps = (p == 0 && i >= 40 && i < 120);
        send_cell(rand_cell());
      end
      no_gaps = 1'b0;
      drain();
    end

    $display("sent %0d cells and checked %0d results over six parameter sets,",
             cells_sent, results_seen);
    $display("including extreme registers, zero divisors and a long output stall");
    if (fails == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
